/* design/csma_pkg.sv */
// ---------------------------------------------------------------------------
// csma_pkg: shared types and constants for the CSMA/CA backoff controller
// Phase and event codes, register indexes, reset values and the LFSR step.
// ---------------------------------------------------------------------------
package csma_pkg;

    // Backoff random generator
    localparam int unsigned RANDOM_WIDTH = 32;
    localparam logic [RANDOM_WIDTH-1:0] RANDOM_POLY = RANDOM_WIDTH'(32'h8020_0003);
    localparam int unsigned STEP_W = $clog2(RANDOM_WIDTH);

    // Field widths
    localparam int unsigned POWER_W    = 16;
    localparam int unsigned WAIT_W     = 10;
    localparam int unsigned SLOT_W     = 8;
    localparam int unsigned CW_BASE_W  = 8;
    localparam int unsigned RETRY_W    = 4;
    localparam int unsigned ATTEMPT_W  = 5;
    localparam int unsigned SLOTS_W    = 23;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // Contention window after the largest shift: base width plus 15
    localparam int unsigned CW_W = CW_BASE_W + 15;

    // Protocol phases
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_AIFS  = 2'd1,
        PH_SLOTS = 2'd2,
        PH_POST  = 2'd3
    } phase_t;

    // Result events
    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_GRANT  = 2'd1,
        EV_DROP   = 2'd2,
        EV_REJECT = 2'd3
    } event_t;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_BUSY_THRESHOLD = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SLOT_TICKS     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_AIFS_CAT0      = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_AIFS_CAT1      = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_CW_BASE_CAT0   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_CW_BASE_CAT1   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_RETRY_LIMIT    = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_RANDOM_SEED    = 3'd7;

    // Register reset values
    localparam logic [POWER_W-1:0]   RST_BUSY_THRESHOLD = 16'sd0;
    localparam logic [SLOT_W-1:0]    RST_SLOT_TICKS     = 8'd13;
    localparam logic [WAIT_W-1:0]    RST_AIFS_CAT0      = 10'd58;
    localparam logic [WAIT_W-1:0]    RST_AIFS_CAT1      = 10'd149;
    localparam logic [CW_BASE_W-1:0] RST_CW_BASE_CAT0   = 8'd3;
    localparam logic [CW_BASE_W-1:0] RST_CW_BASE_CAT1   = 8'd15;
    localparam logic [RETRY_W-1:0]   RST_RETRY_LIMIT    = 4'd15;
    localparam logic [RANDOM_WIDTH-1:0] RST_RANDOM      = RANDOM_WIDTH'(1);

    // Advance the right-shifting Galois LFSR one step, never landing on zero
    function automatic logic [RANDOM_WIDTH-1:0] lfsr_next(input logic [RANDOM_WIDTH-1:0] r);
        logic [RANDOM_WIDTH-1:0] s;
        s = r >> 1;
        if (r[0])
        begin
            s = s ^ RANDOM_POLY;
        end
        if (s == '0)
        begin
            s = RANDOM_WIDTH'(1);
        end
        return s;
    endfunction

endpackage

/* design/csma_ca_backoff_controller.sv */
// ---------------------------------------------------------------------------
// csma_ca_backoff_controller: CSMA/CA access controller with backoff
// Grants, defers, drops or rejects frame requests from one-microsecond channel ticks.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream (s_*) carries one request per item: a tick (s_tuser = 0)
//   with a channel power sample, or a frame request (s_tuser = 1) with its
//   access category. Every request produces exactly one result on the master
//   stream (m_*): the event code in m_tuser and the controller status in
//   m_tdata. The cfg_* channel writes one register per handshake and is
//   always ready; write it only while no request is in flight.
// Sequencing:
//   A request is taken in ST_IDLE and executed in ST_EXEC once the output
//   register can take the result, which is then registered on m_*; s_tready
//   returns when the sequencer is back in ST_IDLE, so a new request is not
//   taken before the last one is executed. A tick that ends an AIFS wait also
//   draws the backoff count; the remainder is formed by a bit-serial restoring
//   divider (ST_DIV), one dividend bit per cycle, while s_tready stays low.
// Reset: rst_n clears the phase to idle, loads the register defaults and
//   seeds the random generator with 1; the block is ready at once.
// Stall: a held result stays in the output register while the next request
//   is accepted; execution of that request waits until the register frees.
// ---------------------------------------------------------------------------
module csma_ca_backoff_controller
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [0] access_category, [16:1] channel_power
    input  logic        s_tuser,   // [0] mode

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] engaged, [5:1] attempt_count, [7:6] phase
    output logic [1:0]  m_tuser,   // [1:0] event_res

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [csma_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [csma_pkg::CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV
    } seq_t;

    localparam logic [csma_pkg::STEP_W-1:0] LAST_STEP =
        csma_pkg::STEP_W'(csma_pkg::RANDOM_WIDTH - 1);

    // Sequencer and captured request
    seq_t                              st_reg, st_next;
    logic                              item_mode_reg, item_mode_next;
    logic                              item_cat_reg, item_cat_next;
    logic [csma_pkg::POWER_W-1:0]      item_power_reg, item_power_next;

    // Configuration registers
    logic [csma_pkg::POWER_W-1:0]      threshold_reg, threshold_next;
    logic [csma_pkg::SLOT_W-1:0]       slot_ticks_reg, slot_ticks_next;
    logic [csma_pkg::WAIT_W-1:0]       aifs0_reg, aifs0_next;
    logic [csma_pkg::WAIT_W-1:0]       aifs1_reg, aifs1_next;
    logic [csma_pkg::CW_BASE_W-1:0]    cw_base0_reg, cw_base0_next;
    logic [csma_pkg::CW_BASE_W-1:0]    cw_base1_reg, cw_base1_next;
    logic [csma_pkg::RETRY_W-1:0]      retry_reg, retry_next;

    // Protocol state
    csma_pkg::phase_t                  phase_reg, phase_next;
    logic                              category_reg, category_next;
    logic [csma_pkg::WAIT_W-1:0]       wait_count_reg, wait_count_next;
    logic [csma_pkg::SLOTS_W-1:0]      slots_left_reg, slots_left_next;
    logic [csma_pkg::ATTEMPT_W-1:0]    attempts_reg, attempts_next;
    logic [csma_pkg::RANDOM_WIDTH-1:0] random_reg, random_next;

    // Shared remainder unit
    logic [csma_pkg::CW_W-1:0]         cw_reg, cw_next;
    logic [csma_pkg::CW_W-1:0]         rem_reg, rem_next;
    logic [csma_pkg::RANDOM_WIDTH-1:0] dividend_reg, dividend_next;
    logic [csma_pkg::STEP_W-1:0]       step_reg, step_next;

    // Output register
    logic                              out_valid_reg, out_valid_next;
    csma_pkg::event_t                  out_event_reg, out_event_next;
    logic                              out_engaged_reg, out_engaged_next;
    logic [csma_pkg::ATTEMPT_W-1:0]    out_attempts_reg, out_attempts_next;
    csma_pkg::phase_t                  out_phase_reg, out_phase_next;

    // Combinational helpers
    logic                              out_free;
    logic                              is_free;
    logic                              cat_sel;
    logic [csma_pkg::WAIT_W-1:0]       aifs_raw;
    logic [csma_pkg::WAIT_W-1:0]       aifs_len;
    logic [csma_pkg::WAIT_W-1:0]       slot_len;
    logic [csma_pkg::CW_BASE_W-1:0]    cw_base_raw;
    logic [csma_pkg::CW_W-1:0]         cw_eff;
    logic [csma_pkg::CW_W:0]           trial;
    logic                              trial_ge;
    logic [csma_pkg::CW_W-1:0]         rem_step;
    logic [csma_pkg::SLOTS_W-1:0]      slots_dec;
    logic [csma_pkg::ATTEMPT_W-1:0]    attempts_inc;
    csma_pkg::event_t                  ev;

    assign s_tready  = (st_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tuser   = out_event_reg;
    assign m_tdata   = {out_phase_reg, out_attempts_reg, out_engaged_reg};
    assign out_free  = !out_valid_reg || m_tready;

    // Compare power against threshold, both signed Q8.8
    assign is_free = $signed(item_power_reg) < $signed(threshold_reg);

    // Category used for AIFS: the request's own on a request; the window uses the stored one
    assign cat_sel     = item_mode_reg ? item_cat_reg : category_reg;
    assign aifs_raw    = cat_sel ? aifs1_reg : aifs0_reg;
    assign aifs_len    = (aifs_raw == '0) ? csma_pkg::WAIT_W'(1) : aifs_raw;
    assign slot_len    = (slot_ticks_reg == '0) ? csma_pkg::WAIT_W'(1)
                                                : csma_pkg::WAIT_W'(slot_ticks_reg);
    assign cw_base_raw = category_reg ? cw_base1_reg : cw_base0_reg;
    assign cw_eff      = csma_pkg::CW_W'((cw_base_raw == '0) ? csma_pkg::CW_BASE_W'(1)
                                                             : cw_base_raw)
                         << attempts_reg[3:0];

    // One restoring division step: shift in the next dividend bit, subtract
    assign trial    = {rem_reg, dividend_reg[csma_pkg::RANDOM_WIDTH-1]};
    assign trial_ge = trial >= {1'b0, cw_reg};
    assign rem_step = trial_ge ? csma_pkg::CW_W'(trial - {1'b0, cw_reg})
                               : csma_pkg::CW_W'(trial);

    assign slots_dec    = (slots_left_reg != '0) ? slots_left_reg - 1'b1 : slots_left_reg;
    assign attempts_inc = attempts_reg + 1'b1;

    // Next-state logic
    always_comb
    begin
        st_next           = st_reg;
        item_mode_next    = item_mode_reg;
        item_cat_next     = item_cat_reg;
        item_power_next   = item_power_reg;
        threshold_next    = threshold_reg;
        slot_ticks_next   = slot_ticks_reg;
        aifs0_next        = aifs0_reg;
        aifs1_next        = aifs1_reg;
        cw_base0_next     = cw_base0_reg;
        cw_base1_next     = cw_base1_reg;
        retry_next        = retry_reg;
        phase_next        = phase_reg;
        category_next     = category_reg;
        wait_count_next   = wait_count_reg;
        slots_left_next   = slots_left_reg;
        attempts_next     = attempts_reg;
        random_next       = random_reg;
        cw_next           = cw_reg;
        rem_next          = rem_reg;
        dividend_next     = dividend_reg;
        step_next         = step_reg;
        out_valid_next    = out_valid_reg && !m_tready;
        out_event_next    = out_event_reg;
        out_engaged_next  = out_engaged_reg;
        out_attempts_next = out_attempts_reg;
        out_phase_next    = out_phase_reg;
        ev                = csma_pkg::EV_NONE;

        // Apply a register write
        if (cfg_valid)
        begin
            unique case (cfg_addr)
                csma_pkg::REG_BUSY_THRESHOLD: threshold_next  = cfg_data[15:0];
                csma_pkg::REG_SLOT_TICKS:     slot_ticks_next = cfg_data[7:0];
                csma_pkg::REG_AIFS_CAT0:      aifs0_next      = cfg_data[9:0];
                csma_pkg::REG_AIFS_CAT1:      aifs1_next      = cfg_data[9:0];
                csma_pkg::REG_CW_BASE_CAT0:   cw_base0_next   = cfg_data[7:0];
                csma_pkg::REG_CW_BASE_CAT1:   cw_base1_next   = cfg_data[7:0];
                csma_pkg::REG_RETRY_LIMIT:    retry_next      = cfg_data[3:0];
                csma_pkg::REG_RANDOM_SEED:
                begin
                    random_next = csma_pkg::RANDOM_WIDTH'(cfg_data);
                    if (random_next == '0)
                    begin
                        random_next = csma_pkg::RST_RANDOM;
                    end
                end
                default: ;
            endcase
        end

        unique case (st_reg)
            // Capture the next request
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    item_mode_next  = s_tuser;
                    item_cat_next   = s_tdata[0];
                    item_power_next = s_tdata[16:1];
                    st_next         = ST_EXEC;
                end
            end

            // Execute one request once the output register can take the result
            ST_EXEC:
            begin
                if (out_free)
                begin
                    st_next = ST_IDLE;
                    if (item_mode_reg)
                    begin
                        if (phase_reg != csma_pkg::PH_IDLE)
                        begin
                            ev = csma_pkg::EV_REJECT;
                        end
                        else
                        begin
                            category_next   = item_cat_reg;
                            attempts_next   = '0;
                            slots_left_next = '0;
                            wait_count_next = aifs_len;
                            if (is_free)
                            begin
                                ev         = csma_pkg::EV_GRANT;
                                phase_next = csma_pkg::PH_POST;
                            end
                            else
                            begin
                                phase_next = csma_pkg::PH_AIFS;
                            end
                        end
                    end
                    else
                    begin
                        unique case (phase_reg)
                            csma_pkg::PH_AIFS:
                            begin
                                if (wait_count_reg <= csma_pkg::WAIT_W'(1))
                                begin
                                    // Step the LFSR and start the remainder draw
                                    random_next     = csma_pkg::lfsr_next(random_reg);
                                    dividend_next   = random_next;
                                    cw_next         = cw_eff;
                                    rem_next        = '0;
                                    step_next       = '0;
                                    wait_count_next = slot_len;
                                    phase_next      = csma_pkg::PH_SLOTS;
                                    st_next         = ST_DIV;
                                end
                                else
                                begin
                                    wait_count_next = wait_count_reg - 1'b1;
                                end
                            end
                            csma_pkg::PH_SLOTS:
                            begin
                                if (wait_count_reg > csma_pkg::WAIT_W'(1))
                                begin
                                    wait_count_next = wait_count_reg - 1'b1;
                                end
                                else if (is_free)
                                begin
                                    slots_left_next = slots_dec;
                                    if (slots_dec == '0)
                                    begin
                                        ev              = csma_pkg::EV_GRANT;
                                        phase_next      = csma_pkg::PH_POST;
                                        wait_count_next = aifs_len;
                                    end
                                    else
                                    begin
                                        wait_count_next = slot_len;
                                    end
                                end
                                else
                                begin
                                    attempts_next   = attempts_inc;
                                    slots_left_next = '0;
                                    if (attempts_inc > csma_pkg::ATTEMPT_W'(retry_reg))
                                    begin
                                        ev              = csma_pkg::EV_DROP;
                                        phase_next      = csma_pkg::PH_IDLE;
                                        wait_count_next = '0;
                                    end
                                    else
                                    begin
                                        phase_next      = csma_pkg::PH_AIFS;
                                        wait_count_next = aifs_len;
                                    end
                                end
                            end
                            csma_pkg::PH_POST:
                            begin
                                if (wait_count_reg <= csma_pkg::WAIT_W'(1))
                                begin
                                    wait_count_next = '0;
                                    phase_next      = csma_pkg::PH_IDLE;
                                end
                                else
                                begin
                                    wait_count_next = wait_count_reg - 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end

                    // Load the result
                    out_valid_next    = 1'b1;
                    out_event_next    = ev;
                    out_engaged_next  = (phase_next != csma_pkg::PH_IDLE);
                    out_attempts_next = attempts_next;
                    out_phase_next    = phase_next;
                end
            end

            // Advance the remainder one dividend bit per cycle
            ST_DIV:
            begin
                rem_next      = rem_step;
                dividend_next = dividend_reg << 1;
                step_next     = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    slots_left_next = csma_pkg::SLOTS_W'(rem_step) + 1'b1;
                    st_next         = ST_IDLE;
                end
            end

            default: st_next = ST_IDLE;
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg           <= ST_IDLE;
            item_mode_reg    <= 1'b0;
            item_cat_reg     <= 1'b0;
            item_power_reg   <= '0;
            threshold_reg    <= csma_pkg::RST_BUSY_THRESHOLD;
            slot_ticks_reg   <= csma_pkg::RST_SLOT_TICKS;
            aifs0_reg        <= csma_pkg::RST_AIFS_CAT0;
            aifs1_reg        <= csma_pkg::RST_AIFS_CAT1;
            cw_base0_reg     <= csma_pkg::RST_CW_BASE_CAT0;
            cw_base1_reg     <= csma_pkg::RST_CW_BASE_CAT1;
            retry_reg        <= csma_pkg::RST_RETRY_LIMIT;
            phase_reg        <= csma_pkg::PH_IDLE;
            category_reg     <= 1'b0;
            wait_count_reg   <= '0;
            slots_left_reg   <= '0;
            attempts_reg     <= '0;
            random_reg       <= csma_pkg::RST_RANDOM;
            cw_reg           <= '0;
            rem_reg          <= '0;
            dividend_reg     <= '0;
            step_reg         <= '0;
            out_valid_reg    <= 1'b0;
            out_event_reg    <= csma_pkg::EV_NONE;
            out_engaged_reg  <= 1'b0;
            out_attempts_reg <= '0;
            out_phase_reg    <= csma_pkg::PH_IDLE;
        end
        else
        begin
            st_reg           <= st_next;
            item_mode_reg    <= item_mode_next;
            item_cat_reg     <= item_cat_next;
            item_power_reg   <= item_power_next;
            threshold_reg    <= threshold_next;
            slot_ticks_reg   <= slot_ticks_next;
            aifs0_reg        <= aifs0_next;
            aifs1_reg        <= aifs1_next;
            cw_base0_reg     <= cw_base0_next;
            cw_base1_reg     <= cw_base1_next;
            retry_reg        <= retry_next;
            phase_reg        <= phase_next;
            category_reg     <= category_next;
            wait_count_reg   <= wait_count_next;
            slots_left_reg   <= slots_left_next;
            attempts_reg     <= attempts_next;
            random_reg       <= random_next;
            cw_reg           <= cw_next;
            rem_reg          <= rem_next;
            dividend_reg     <= dividend_next;
            step_reg         <= step_next;
            out_valid_reg    <= out_valid_next;
            out_event_reg    <= out_event_next;
            out_engaged_reg  <= out_engaged_next;
            out_attempts_reg <= out_attempts_next;
            out_phase_reg    <= out_phase_next;
        end
    end

endmodule
